// ----- rtl/yrf_pkg.sv -----
// ----------------------------------------------------------------------------
// yrf_pkg
// Shared types, constants and helpers for the YUYV to RGB24 flip converter.
// ----------------------------------------------------------------------------
`default_nettype none

package yrf_pkg;

    // field and register widths
    localparam int BYTE_W      = 8;
    localparam int CFG_W       = 13;
    localparam int COORD_W     = 12;
    localparam int MAX_DIM_DEF = 4096;

    // register reset values
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // configuration register indexes
    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // color matrix coefficients, scaled by 100
    localparam int COEF_RV = 140;
    localparam int COEF_GU = 34;
    localparam int COEF_GV = 71;
    localparam int COEF_BU = 177;

    // divide by 100 as multiply by 5243 and shift by 19 (exact for products below 43690)
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_W     = 20;

    // chroma offset and width of one scaled chroma term
    localparam int CHROMA_MID = 128;
    localparam int TERM_W     = 9;
    localparam int SUM_W      = 11;

    // scaled chroma terms shared by both pixels of a macropixel
    typedef struct packed {
        logic signed [TERM_W-1:0] red_v;
        logic signed [TERM_W-1:0] green_u;
        logic signed [TERM_W-1:0] green_v;
        logic signed [TERM_W-1:0] blue_u;
    } chroma_t;

    // one converted pixel
    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } pix_t;

    // clamp a signed sum into 0..255
    function automatic logic [BYTE_W-1:0] sat8(input logic signed [SUM_W-1:0] v);
        logic [BYTE_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > SUM_W'(255)) begin
            res = '1;
        end else begin
            res = v[BYTE_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/yrf_chroma.sv -----
// ----------------------------------------------------------------------------
// yrf_chroma
// Chroma scaling: four coefficient products of U-128 and V-128, each divided
// by 100 with truncation toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module yrf_chroma
    import yrf_pkg::*;
(
    input  wire logic [BYTE_W-1:0] chroma_blue,
    input  wire logic [BYTE_W-1:0] chroma_red,
    output chroma_t                terms
);

    // coefficient folded into the reciprocal, so one multiply per term
    localparam logic [RECIP_W-1:0] K_RV = RECIP_W'(COEF_RV * RECIP_100);
    localparam logic [RECIP_W-1:0] K_GU = RECIP_W'(COEF_GU * RECIP_100);
    localparam logic [RECIP_W-1:0] K_GV = RECIP_W'(COEF_GV * RECIP_100);
    localparam logic [RECIP_W-1:0] K_BU = RECIP_W'(COEF_BU * RECIP_100);
    localparam int PROD_W = BYTE_W + 1 + RECIP_W;

    // sign-magnitude scale, quotient truncated toward zero
    function automatic logic signed [TERM_W-1:0] scale(input logic signed [BYTE_W:0] off,
                                                       input logic [RECIP_W-1:0] k);
        logic [BYTE_W:0]       mag;
        logic [PROD_W-1:0]     prod;
        logic [TERM_W-1:0]     quo;
        mag  = off[BYTE_W] ? (~off + 1'b1) : off;
        prod = PROD_W'(mag) * PROD_W'(k);
        quo  = prod[RECIP_SHIFT +: TERM_W];
        return off[BYTE_W] ? $signed(~quo + 1'b1) : $signed(quo);
    endfunction

    logic signed [BYTE_W:0] d_off;
    logic signed [BYTE_W:0] e_off;

    // remove the chroma offset
    assign d_off = $signed({1'b0, chroma_blue}) - $signed((BYTE_W+1)'(CHROMA_MID));
    assign e_off = $signed({1'b0, chroma_red})  - $signed((BYTE_W+1)'(CHROMA_MID));

    // the four scaled terms
    always_comb begin
        terms.red_v   = scale(e_off, K_RV);
        terms.green_u = scale(d_off, K_GU);
        terms.green_v = scale(e_off, K_GV);
        terms.blue_u  = scale(d_off, K_BU);
    end

endmodule

`default_nettype wire

// ----- rtl/yrf_lane.sv -----
// ----------------------------------------------------------------------------
// yrf_lane
// One pixel lane: adds the shared red and blue chroma terms to its luma,
// subtracts both green terms from it and saturates each channel.
// ----------------------------------------------------------------------------
`default_nettype none

module yrf_lane
    import yrf_pkg::*;
(
    input  wire logic [BYTE_W-1:0] luma,
    input  wire chroma_t           terms,
    output pix_t                   pix
);

    logic signed [SUM_W-1:0] y_s;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] g_sum;
    logic signed [SUM_W-1:0] b_sum;

    // channel sums
    always_comb begin
        y_s   = $signed(SUM_W'({1'b0, luma}));
        r_sum = y_s + SUM_W'(terms.red_v);
        g_sum = y_s - SUM_W'(terms.green_u) - SUM_W'(terms.green_v);
        b_sum = y_s + SUM_W'(terms.blue_u);
    end

    // saturate
    always_comb begin
        pix.red   = sat8(r_sum);
        pix.green = sat8(g_sum);
        pix.blue  = sat8(b_sum);
    end

endmodule

`default_nettype wire

// ----- rtl/yrf_merge.sv -----
// ----------------------------------------------------------------------------
// yrf_merge
// Merge stage: holds the pixel pair from the lanes, sends it out one pixel
// a cycle while the output is ready and tags each pixel with its column and flipped row.
// ----------------------------------------------------------------------------
`default_nettype none

module yrf_merge
    import yrf_pkg::*;
#(
    parameter int EW = CFG_W
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  pair_valid,
    output logic                       pair_ready,
    input  wire pix_t                  pix_first,
    input  wire pix_t                  pix_second,
    input  wire logic [EW-1:0]         width_eff,
    input  wire logic [EW-1:0]         height_eff,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // blue [7:0], green [15:8], red [23:16], out_row [35:24], out_col [47:36]
    output logic [47:0]                m_axis_tdata,
    // pair_last [0]
    output logic                       m_axis_tuser,
    output logic                       m_axis_tlast
);

    logic          full_reg,  full_next;
    logic          phase_reg, phase_next;
    pix_t          pix0_reg,  pix1_reg;
    logic [EW-1:0] col_reg,   col_next;
    logic [EW-1:0] row_reg,   row_next;

    logic          out_fire;
    logic [EW-1:0] col_pre;
    logic [EW-1:0] row_step;
    logic [EW-1:0] row_pre;
    logic [EW-1:0] col_inc;
    logic [EW-1:0] row_inc;
    logic [EW-1:0] row_flip;
    pix_t          pix_cur;

    assign out_fire   = full_reg && m_axis_tready;
    assign pair_ready = !full_reg || (phase_reg && m_axis_tready);

    // pair buffer control
    always_comb begin
        full_next  = full_reg;
        phase_next = phase_reg;
        if (pair_ready) begin
            full_next  = pair_valid;
            phase_next = 1'b0;
        end else if (out_fire) begin
            phase_next = 1'b1;
        end
    end

    // wrap a counter left out of range by a register change
    always_comb begin
        col_pre  = col_reg;
        row_step = row_reg;
        if (col_reg >= width_eff) begin
            col_pre  = '0;
            row_step = row_reg + 1'b1;
        end
        row_pre = (row_step >= height_eff) ? '0 : row_step;
    end

    // advance past the pixel being sent
    always_comb begin
        col_inc  = col_pre + 1'b1;
        row_inc  = row_pre + 1'b1;
        col_next = col_reg;
        row_next = row_reg;
        if (out_fire) begin
            if (col_inc >= width_eff) begin
                col_next = '0;
                row_next = (row_inc >= height_eff) ? '0 : row_inc;
            end else begin
                col_next = col_inc;
                row_next = row_pre;
            end
        end
    end

    // result fields
    always_comb begin
        row_flip      = height_eff - 1'b1 - row_pre;
        pix_cur       = phase_reg ? pix1_reg : pix0_reg;
        m_axis_tvalid = full_reg;
        m_axis_tdata  = {col_pre[COORD_W-1:0], row_flip[COORD_W-1:0],
                         pix_cur.red, pix_cur.green, pix_cur.blue};
        m_axis_tuser  = phase_reg;
        m_axis_tlast  = (col_pre == width_eff - 1'b1) && (row_pre == height_eff - 1'b1);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg  <= 1'b0;
            phase_reg <= 1'b0;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            full_reg  <= full_next;
            phase_reg <= phase_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    // pixel pair
    always_ff @(posedge aclk) begin
        if (pair_ready) begin
            pix0_reg <= pix_first;
            pix1_reg <= pix_second;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/yuyv_to_rgb24_flip_top.sv -----
// ----------------------------------------------------------------------------
// yuyv_to_rgb24_flip_top
// YUYV 4:2:2 macropixel to two BGR24 pixels with column and flipped row.
// ----------------------------------------------------------------------------
// Path: a macropixel is registered in the input stage, then in the merge stage pair
// buffer; its second pixel goes out after the first pixel is taken.
// The single pixel-wide output port of the merge stage sends the two pixels in turn;
// the input stage can take a new macropixel while the merge stage sends the last pair.
// Reset: clears all valid flags and both counters, dimensions return to 640x480.
`default_nettype none

module yuyv_to_rgb24_flip_top
    import yrf_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration writes
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    // input macropixels
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // luma_first [7:0], chroma_blue [15:8], luma_second [23:16], chroma_red [31:24]
    input  wire logic [31:0]       s_axis_tdata,
    // result pixels
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // blue [7:0], green [15:8], red [23:16], out_row [35:24], out_col [47:36]
    output logic [47:0]            m_axis_tdata,
    // pair_last [0]
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int EW    = (DIM_W > CFG_W) ? DIM_W : CFG_W;

    logic [EW-1:0]     width_reg,  width_next;
    logic [EW-1:0]     height_reg, height_next;
    logic [EW-1:0]     wdata_ext;
    logic [EW-1:0]     wdata_eff;

    logic              s1_valid_reg, s1_valid_next;
    chroma_t           terms_reg;
    logic [BYTE_W-1:0] luma0_reg;
    logic [BYTE_W-1:0] luma1_reg;

    chroma_t           terms;
    pix_t              pix0;
    pix_t              pix1;
    logic              pair_ready;
    logic              s_fire;

    // clamp written dimension into 1..MAX_DIM
    always_comb begin
        wdata_ext = EW'(cfg_wdata);
        if (wdata_ext == '0) begin
            wdata_eff = EW'(1);
        end else if (wdata_ext > EW'(MAX_DIM)) begin
            wdata_eff = EW'(MAX_DIM);
        end else begin
            wdata_eff = wdata_ext;
        end
    end

    // dimension registers
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_next  = wdata_eff;
                REG_FRAME_HEIGHT: height_next = wdata_eff;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= EW'(RESET_WIDTH);
            height_reg <= EW'(RESET_HEIGHT);
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // chroma scaling of the incoming request
    yrf_chroma u_chroma (
        .chroma_blue (s_axis_tdata[15:8]),
        .chroma_red  (s_axis_tdata[31:24]),
        .terms       (terms)
    );

    // input stage handshake
    assign s_axis_tready = !s1_valid_reg || pair_ready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_fire) begin
            s1_valid_next = 1'b1;
        end else if (pair_ready) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            terms_reg <= terms;
            luma0_reg <= s_axis_tdata[7:0];
            luma1_reg <= s_axis_tdata[23:16];
        end
    end

    // two pixel lanes
    yrf_lane u_lane0 (
        .luma  (luma0_reg),
        .terms (terms_reg),
        .pix   (pix0)
    );

    yrf_lane u_lane1 (
        .luma  (luma1_reg),
        .terms (terms_reg),
        .pix   (pix1)
    );

    // serialize the pair and attach coordinates
    yrf_merge #(
        .EW (EW)
    ) u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pair_valid    (s1_valid_reg),
        .pair_ready    (pair_ready),
        .pix_first     (pix0),
        .pix_second    (pix1),
        .width_eff     (width_reg),
        .height_eff    (height_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/yrf_checker.sv -----
// ----------------------------------------------------------------------------
// yrf_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module yrf_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [47:0]       m_axis_tdata,
    input wire logic              m_axis_tuser,
    input wire logic              m_axis_tlast
);

    // nothing comes out right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // the second pixel of a pair follows the first at once
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tuser |=> m_axis_tvalid && m_axis_tuser)
        else $error("second pixel of pair missing");

    // last pixel of a frame lands on flipped row zero
    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[35:24] == '0)
        else $error("frame end not on row zero");

    // a stalled result keeps its pair position
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind yuyv_to_rgb24_flip_top yrf_checker u_yrf_checker (.*);

`default_nettype wire
